// ===== hw/rtl/blm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_pkg
// Shared widths, constants and control types for the block level meter.
// ----------------------------------------------------------------------------
package blm_pkg;

  // frame bound, capped at what the frame counter can hold
  localparam int MAX_FRAMES  = 4096;
  localparam int COUNT_W     = 13;
  localparam int COUNT_LIMIT = (2 ** COUNT_W) - 1;
  localparam int BOUND_INT   = (MAX_FRAMES > COUNT_LIMIT) ? COUNT_LIMIT :
                               ((MAX_FRAMES < 1) ? 1 : MAX_FRAMES);
  localparam logic [COUNT_W-1:0] FRAME_BOUND = COUNT_W'(BOUND_INT);

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = 42;
  localparam int LEVEL_W  = 17;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int SREM_W   = ROOT_W + 1;

  // iterative unit lengths
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // level_mode codes
  localparam logic [1:0] MODE_LAST = 2'd0;
  localparam logic [1:0] MODE_PEAK = 2'd1;
  localparam logic [1:0] MODE_RMS  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take;         // sample item accepted
    logic take_end;     // accepted item closes the block
    logic load_direct;  // result from last sample or peak
    logic start_div;    // snapshot block sums into the divider
    logic div_step;
    logic sqrt_step;
    logic load_rms;     // result from the square root
  } blm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode_rms;
    logic out_free;
  } blm_sts_t;

endpackage

// ===== hw/rtl/blm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_ifs
// Valid/ready channels of the block level meter: samples, levels, config.
// ----------------------------------------------------------------------------
interface blm_sample_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] sample;
  logic        block_end;
  modport source (output valid, sample, block_end, input ready);
  modport sink   (input valid, sample, block_end, output ready);
endinterface

interface blm_level_if;
  logic        valid;
  logic        ready;
  logic signed [16:0] level;
  logic        overrun;
  modport source (output valid, level, overrun, input ready);
  modport sink   (input valid, level, overrun, output ready);
endinterface

interface blm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] level_mode;
  modport source (output valid, level_mode, input ready);
  modport sink   (input valid, level_mode, output ready);
endinterface

// ===== hw/rtl/blm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_ctrl
// Sequencer: sample intake, divide and square root passes, result load.
// ----------------------------------------------------------------------------
module blm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_block_end,
  output logic                in_ready,
  input  blm_pkg::blm_sts_t   sts,
  output blm_pkg::blm_cmd_t   cmd
);

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [blm_pkg::STEP_W-1:0] DIV_LAST  =
    blm_pkg::STEP_W'(blm_pkg::DIV_STEPS - 1);
  localparam logic [blm_pkg::STEP_W-1:0] SQRT_LAST =
    blm_pkg::STEP_W'(blm_pkg::SQRT_STEPS - 1);

  logic [1:0]                 state, state_next;
  logic [blm_pkg::STEP_W-1:0] step, step_next;
  logic                       take;

  // a block end waits until the result register can take its level
  assign in_ready = (state == ST_ACC) && (sts.out_free || !in_block_end);
  assign take     = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      ST_ACC: begin
        cmd.take     = take;
        cmd.take_end = take && in_block_end;
        if (take && in_block_end) begin
          if (sts.mode_rms) begin
            cmd.start_div = 1'b1;
            step_next     = '0;
            state_next    = ST_DIV;
          end else begin
            cmd.load_direct = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step == DIV_LAST) begin
          step_next  = '0;
          state_next = ST_SQRT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == SQRT_LAST) begin
          step_next  = '0;
          state_next = ST_OUT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_rms = 1'b1;
          state_next   = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== hw/rtl/blm_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blm_dpath
// Accumulators, shared shift register for the divider and square root,
// and the result register.
// ----------------------------------------------------------------------------
module blm_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_mode,
  input  logic signed [blm_pkg::SAMPLE_W-1:0] sample,
  input  logic                          out_ready,
  input  blm_pkg::blm_cmd_t             cmd,
  output blm_pkg::blm_sts_t             sts,
  output logic                          out_valid,
  output logic signed [blm_pkg::LEVEL_W-1:0] out_level,
  output logic                          out_overrun
);

  localparam int SUM_W   = blm_pkg::SUM_W;
  localparam int COUNT_W = blm_pkg::COUNT_W;
  localparam int ROOT_W  = blm_pkg::ROOT_W;
  localparam int SREM_W  = blm_pkg::SREM_W;

  logic [1:0]                  level_mode;
  logic [blm_pkg::MAG_W-1:0]   peak;
  logic [SUM_W-1:0]            sum;
  logic [COUNT_W-1:0]          count;
  logic                        ovr;

  logic [blm_pkg::LEVEL_W-1:0] s_ext, mag_ext;
  logic [blm_pkg::MAG_W-1:0]   mag, peak_next;
  logic [blm_pkg::SQ_W-1:0]    sq;
  logic [SUM_W:0]              sum_add;
  logic [SUM_W-1:0]            sum_next;
  logic [COUNT_W-1:0]          count_next;
  logic                        ovr_next, at_bound;
  logic [blm_pkg::LEVEL_W-1:0] direct_level;

  logic [SUM_W-1:0]            quot;
  logic [COUNT_W-1:0]          divisor;
  logic [COUNT_W-1:0]          drem;
  logic [COUNT_W:0]            drem_sh;
  logic                        div_ge;
  logic [ROOT_W-1:0]           root;
  logic [SREM_W-1:0]           srem;
  logic [SREM_W+1:0]           srem_sh, trial;
  logic                        sqrt_ge;
  logic                        ovr_hold;

  // sample magnitude and running sums including this item
  always_comb begin
    s_ext      = {sample[blm_pkg::SAMPLE_W-1], sample};
    mag_ext    = sample[blm_pkg::SAMPLE_W-1] ? (~s_ext + 1'b1) : s_ext;
    mag        = mag_ext[blm_pkg::MAG_W-1:0];
    peak_next  = (mag > peak) ? mag : peak;
    at_bound   = (count >= blm_pkg::FRAME_BOUND);
    sq         = mag * mag;
    sum_add    = {1'b0, sum} + (SUM_W + 1)'(sq);
    sum_next   = at_bound ? sum : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
    count_next = at_bound ? count : count + 1'b1;
    ovr_next   = ovr | at_bound;
  end

  // level for last sample and peak modes
  assign direct_level = (level_mode == blm_pkg::MODE_PEAK) ?
                        {1'b0, peak_next} : s_ext;

  // restoring divide step, one quotient bit a cycle
  assign drem_sh = {drem, quot[SUM_W-1]};
  assign div_ge  = (drem_sh >= {1'b0, divisor});

  // square root step, two radicand bits a cycle
  assign srem_sh = {srem, quot[SUM_W-1:SUM_W-2]};
  assign trial   = {1'b0, root, 2'b01};
  assign sqrt_ge = (srem_sh >= trial);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      level_mode <= blm_pkg::MODE_LAST;
    end else if (cfg_we) begin
      level_mode <= cfg_mode;
    end
  end

  // block accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      peak  <= '0;
      sum   <= '0;
      count <= '0;
      ovr   <= 1'b0;
    end else if (cmd.take_end) begin
      peak  <= '0;
      sum   <= '0;
      count <= '0;
      ovr   <= 1'b0;
    end else if (cmd.take) begin
      peak  <= peak_next;
      sum   <= sum_next;
      count <= count_next;
      ovr   <= ovr_next;
    end
  end

  // shared divider and square root registers
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      quot     <= sum_next;
      divisor  <= count_next;
      drem     <= '0;
      root     <= '0;
      srem     <= '0;
      ovr_hold <= ovr_next;
    end else if (cmd.div_step) begin
      drem <= div_ge ? COUNT_W'(drem_sh - {1'b0, divisor}) : drem_sh[COUNT_W-1:0];
      quot <= {quot[SUM_W-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      srem <= sqrt_ge ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
      root <= {root[ROOT_W-2:0], sqrt_ge};
      quot <= {quot[SUM_W-3:0], 2'b00};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_direct || cmd.load_rms) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      out_level   <= direct_level;
      out_overrun <= ovr_next;
    end else if (cmd.load_rms) begin
      out_level   <= root[blm_pkg::LEVEL_W-1:0];
      out_overrun <= ovr_hold;
    end
  end

  // status
  assign sts.mode_rms = (level_mode == blm_pkg::MODE_RMS);
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== hw/rtl/block_level_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_level_meter
// Block-wise peak, RMS or last-sample level of signed Q1.15 audio.
// ----------------------------------------------------------------------------
//  channel   dir  payload                        item
//  samples   in   sample[15:0], block_end        one audio sample
//  levels    out  level[16:0], overrun           one level per block
//  cfg       in   level_mode[1:0]                mode register write
//
// A block end in last sample or peak mode loads its level as it is taken; in
// RMS mode the intake is followed by the restoring divider and the square
// root, which share one shift register, and the result load, and no sample
// is taken until that load. Reset clears the accumulators and sets
// level_mode to 0. A block end is held off while an unread level sits in the
// output register; other samples keep flowing.
// ----------------------------------------------------------------------------
module block_level_meter (
  input  logic          clk,
  input  logic          rst,
  blm_sample_if.sink    samples,
  blm_level_if.source   levels,
  blm_cfg_if.sink       cfg
);

  blm_pkg::blm_cmd_t cmd;
  blm_pkg::blm_sts_t sts;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  // sequencer
  blm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (samples.valid),
    .in_block_end (samples.block_end),
    .in_ready     (samples.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // accumulators, divide, root, result
  blm_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg.valid),
    .cfg_mode    (cfg.level_mode),
    .sample      (samples.sample),
    .out_ready   (levels.ready),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (levels.valid),
    .out_level   (levels.level),
    .out_overrun (levels.overrun)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_level_meter: random-gapped sample items go in,
// an in-bench meter model predicts each block level, and every level item
// that comes out is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  // alias code for last-sample mode
  localparam logic [1:0] MODE_LAST_ALT = 2'd3;
  localparam longint SUM_SAT = (64'd1 << blm_pkg::SUM_W) - 1;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS = 155;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic signed [blm_pkg::LEVEL_W-1:0] level;
    logic                               overrun;
  } level_item_t;

  logic clk;
  logic rst;

  blm_sample_if sample_ch ();
  blm_level_if  level_ch ();
  blm_cfg_if    cfg_ch ();

  block_level_meter uut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .levels  (level_ch),
    .cfg     (cfg_ch)
  );

  // meter model state
  logic [1:0]  meter_mode;
  longint      meter_peak;
  longint      meter_sumsq;
  longint      meter_count;
  logic        meter_over;
  level_item_t levels_due[$];

  int  mismatch_count;
  bit  src_idle_on;
  bit  sink_idle_on;
  int  sink_hold_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // overall time limit
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // gap length: mostly none, mostly short otherwise, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample content: extremes, full range and quiet signal
  function automatic logic signed [15:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        3: return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    if (pick < 6) return 16'($urandom);
    return 16'($signed($urandom_range(0, 511)) - 256);
  endfunction

  function automatic logic [20:0] floor_sqrt(input logic [63:0] v);
    logic [20:0] root;
    logic [20:0] trial;
    root = '0;
    for (int i = 20; i >= 0; i--) begin
      trial = root | (21'd1 << i);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // update the meter model with one accepted sample
  task automatic take_sample(input logic signed [15:0] smp, input logic last);
    longint      mag;
    longint      sq;
    level_item_t res;
    mag = (smp < 0) ? -longint'(smp) : longint'(smp);
    if (mag > meter_peak) meter_peak = mag;
    if (meter_count >= longint'(blm_pkg::FRAME_BOUND)) begin
      meter_over = 1'b1;
    end else begin
      sq = mag * mag;
      if (sq > SUM_SAT - meter_sumsq) meter_sumsq = SUM_SAT;
      else meter_sumsq = meter_sumsq + sq;
      meter_count++;
    end
    if (last) begin
      case (meter_mode)
        blm_pkg::MODE_PEAK: res.level = blm_pkg::LEVEL_W'(meter_peak);
        blm_pkg::MODE_RMS:
          res.level = blm_pkg::LEVEL_W'(floor_sqrt(meter_sumsq / meter_count));
        default:   res.level = {smp[15], smp};
      endcase
      res.overrun = meter_over;
      levels_due.push_back(res);
      meter_peak  = 0;
      meter_sumsq = 0;
      meter_count = 0;
      meter_over  = 1'b0;
    end
  endtask

  // offer one sample item and wait for it to be taken
  task automatic send_sample(input logic signed [15:0] smp, input logic last);
    int gap;
    sample_ch.valid     <= 1'b1;
    sample_ch.sample    <= smp;
    sample_ch.block_end <= last;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    take_sample(smp, last);
    gap = src_idle_on ? idle_len() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  // pause input until every predicted level has come out, then let it settle
  task automatic wait_levels_drained();
    sample_ch.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_levels_drained();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.level_mode <= m;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    meter_mode = m;
  endtask

  // level sink: random stalls plus a counted long hold when asked
  initial begin : level_sink
    int stall_left;
    stall_left = 0;
    level_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_left > 0) begin
        level_ch.ready <= 1'b0;
        sink_hold_left--;
      end else if (stall_left > 0) begin
        level_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        level_ch.ready <= 1'b1;
        if (sink_idle_on) stall_left = idle_len();
      end
    end
  end

  // compare each level item with the oldest prediction
  initial begin : level_check
    level_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && level_ch.valid === 1'b1 && level_ch.ready === 1'b1) begin
        if (levels_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected level item: level %0d overrun %0d",
                     level_ch.level, level_ch.overrun);
        end else begin
          want = levels_due.pop_front();
          if (level_ch.level !== want.level || level_ch.overrun !== want.overrun) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display({"level mismatch: expected level %0d overrun %0d, ",
                        "got level %0d overrun %0d"},
                       want.level, want.overrun, level_ch.level, level_ch.overrun);
          end
        end
      end
    end
  end

  // last-sample mode over the sample extremes
  task automatic test_mode_last();
    set_mode(blm_pkg::MODE_LAST);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh0005, 1'b0);
    send_sample(16'shffff, 1'b1);
  endtask

  // peak mode, including the full-scale negative magnitude
  task automatic test_mode_peak();
    set_mode(blm_pkg::MODE_PEAK);
    send_sample(16'sh0003, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0064, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'shfffb, 1'b1);
    send_sample(16'sh0000, 1'b1);
  endtask

  // rms mode: single full-scale samples, rounding down, a block that averages to zero
  task automatic test_mode_rms();
    set_mode(blm_pkg::MODE_RMS);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0003, 1'b0);
    send_sample(16'sh0004, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7fff, 1'b1);
  endtask

  // mode code 3 behaves as last sample
  task automatic test_mode_alias();
    set_mode(MODE_LAST_ALT);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'shfff9, 1'b1);
    send_sample(16'sh3039, 1'b1);
  endtask

  // long output hold while short rms blocks keep arriving, so input backs up
  task automatic test_output_stall();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_mode(blm_pkg::MODE_RMS);
    sink_hold_left = 400;
    for (int b = 0; b < 40; b++) send_block($urandom_range(1, 3));
    wait_levels_drained();
  endtask

  // random blocks over several mode settings and idling patterns
  task automatic test_random_blocks();
    logic [1:0] modes[8];
    int         sent;
    int         len;
    int         pick;
    modes = '{MODE_LAST_ALT, blm_pkg::MODE_RMS, blm_pkg::MODE_PEAK, blm_pkg::MODE_LAST,
              blm_pkg::MODE_RMS, blm_pkg::MODE_PEAK, MODE_LAST_ALT, blm_pkg::MODE_RMS};
    foreach (modes[p]) begin
      src_idle_on  = (p != 4);
      sink_idle_on = (p != 4);
      set_mode(modes[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 300);
        // last block of a phase is cut to the phase budget
        if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
        send_block(len);
        sent += len;
        // in phase 2, once at the halfway point, the sender holds off until the output has caught up
        if (p == 2 && sent >= PHASE_ITEMS / 2 && sent - len < PHASE_ITEMS / 2)
          wait_levels_drained();
      end
    end
  endtask

  // test sequence
  initial begin
    rst                 <= 1'b1;
    sample_ch.valid     <= 1'b0;
    sample_ch.sample    <= '0;
    sample_ch.block_end <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.level_mode   <= blm_pkg::MODE_LAST;
    mismatch_count = 0;
    sink_hold_left = 0;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    meter_mode     = blm_pkg::MODE_LAST;
    meter_peak     = 0;
    meter_sumsq    = 0;
    meter_count    = 0;
    meter_over     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_mode_last();
    test_mode_peak();
    test_mode_rms();
    test_mode_alias();
    test_output_stall();
    test_random_blocks();

    wait_levels_drained();
    if (mismatch_count == 0 && levels_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/blm_pkg.sv
hw/rtl/blm_ifs.sv
hw/rtl/blm_ctrl.sv
hw/rtl/blm_dpath.sv
hw/rtl/block_level_meter.sv
dv/tb.sv
